// File: hw/rtl/bgh3d_pkg.sv
`timescale 1ns / 1ps
// Package for the 3D binary geohash block: widths, register indexes,
// pipeline stage and configuration types, per-stage dimension selection.
// No dependencies.
package bgh3d_pkg;

    localparam int COORD_W   = 32;
    localparam int HASH_W    = 32;
    localparam int LEN_W     = 6;
    localparam int DIMS_W    = 2;
    localparam int NUM_DIMS  = 3;
    localparam int NSTAGE    = HASH_W;
    localparam int IDX_W     = 4;

    localparam logic [IDX_W-1:0] REG_LOWER_X     = 4'd0;
    localparam logic [IDX_W-1:0] REG_LOWER_Y     = 4'd1;
    localparam logic [IDX_W-1:0] REG_LOWER_Z     = 4'd2;
    localparam logic [IDX_W-1:0] REG_UPPER_X     = 4'd3;
    localparam logic [IDX_W-1:0] REG_UPPER_Y     = 4'd4;
    localparam logic [IDX_W-1:0] REG_UPPER_Z     = 4'd5;
    localparam logic [IDX_W-1:0] REG_HASH_LENGTH = 4'd6;
    localparam logic [IDX_W-1:0] REG_DIMS_USED   = 4'd7;

    localparam logic [COORD_W-1:0] LOWER_RESET = 32'h8000_0000;
    localparam logic [COORD_W-1:0] UPPER_RESET = 32'h7FFF_FFFF;
    localparam logic [LEN_W-1:0]   LEN_RESET   = 6'd30;
    localparam logic [DIMS_W-1:0]  DIMS_RESET  = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;

    // One point travelling down the bisection pipeline
    typedef struct packed {
        coord_t [NUM_DIMS-1:0] pt;
        coord_t [NUM_DIMS-1:0] lo;
        coord_t [NUM_DIMS-1:0] hi;
        logic   [HASH_W-1:0]   code;
    } stage_t;

    typedef struct packed {
        coord_t [NUM_DIMS-1:0] lower;
        coord_t [NUM_DIMS-1:0] upper;
        logic   [LEN_W-1:0]    hash_length;
        logic   [DIMS_W-1:0]   dims_used;
    } cfg_t;

    // Dimension bisected by stage idx; zero dims behaves as one
    function automatic logic [DIMS_W-1:0] stage_dim(input int unsigned idx,
                                                    input logic [DIMS_W-1:0] dims);
        logic [DIMS_W-1:0] sel;
        sel = '0;
        case (dims)
            2'd2:    sel = DIMS_W'(idx % 2);
            2'd3:    sel = DIMS_W'(idx % 3);
            default: sel = '0;
        endcase
        return sel;
    endfunction

endpackage

// File: hw/rtl/binary_geohash_3d_top.sv
`timescale 1ns / 1ps
// Top level of the 3D binary geohash block: config port, 32-stage pipeline.
// Depends on bgh3d_pkg, bgh3d_cfg, bgh3d_stage.
//
// Each point beat on s_* is split into x, y, z (32-bit signed fixed point)
// and pushed through a pipeline of 32 bisection stages, one per possible hash
// bit, with one register per stage. A new point can enter every cycle while
// the pipeline is not full and stalled; the result beat on m_* comes from the
// last stage register. Stage k bisects dimension k mod dims_used
// and only contributes a bit when k < hash_length, so shorter hashes simply
// pass through the tail stages and come out right-aligned, first decision in
// bit hash_length-1. Each stage register advances whenever the register after
// it is empty or itself advancing, so bubbles close up under back-pressure and
// the input keeps being taken until every stage holds a point. Configuration
// writes (index 0..7, higher indexes ignored) are always accepted and must
// only happen while no point is in flight; stages read live length and dims.
module binary_geohash_3d_top
    import bgh3d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // point input: [31:0] point_x, [63:32] point_y, [95:64] point_z
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [95:0]        s_tdata,
    // result output: [31:0] geo_hash
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,
    // register write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [COORD_W-1:0] cfg_data
);

    cfg_t              cfg;
    stage_t            pipe   [0:NSTAGE];
    logic [NSTAGE:0]   vld;
    logic [NSTAGE+1:1] can_take;

    // Register write port never back-pressures
    assign cfg_ready = 1'b1;

    bgh3d_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Seed the pipeline with the point and the configured corners
    always_comb
    begin
        pipe[0].pt[0] = s_tdata[31:0];
        pipe[0].pt[1] = s_tdata[63:32];
        pipe[0].pt[2] = s_tdata[95:64];
        pipe[0].lo    = cfg.lower;
        pipe[0].hi    = cfg.upper;
        pipe[0].code  = '0;
    end
    assign vld[0] = s_tvalid;

    // Ready ripples back from the output: a register can take a beat when
    // it is empty or its own content moves on this cycle
    assign can_take[NSTAGE+1] = m_tready;

    genvar gi;
    generate
        for (gi = 0; gi < NSTAGE; gi++)
        begin : g_stage
            assign can_take[gi+1] = !vld[gi+1] || can_take[gi+2];

            bgh3d_stage u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (can_take[gi+1]),
                .in_valid  (vld[gi]),
                .in_data   (pipe[gi]),
                .dim_sel   (stage_dim(gi, cfg.dims_used)),
                .active    (cfg.hash_length > LEN_W'(gi)),
                .out_valid (vld[gi+1]),
                .out_data  (pipe[gi+1])
            );
        end
    endgenerate

    assign s_tready = can_take[1];
    assign m_tvalid = vld[NSTAGE];
    assign m_tdata  = pipe[NSTAGE].code;

    // Input only stalls when every stage is holding a point
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&vld[NSTAGE:1]))
        else $error("input stalled with a bubble in the pipeline");

    // An accepted point lands in the first stage register
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld[1])
        else $error("accepted point lost at pipeline entry");

    // Hash bits above the configured length stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (cfg.hash_length < LEN_W'(HASH_W)))
            |-> ((m_tdata >> cfg.hash_length) == '0))
        else $error("hash bits set above configured length");

endmodule

// File: hw/rtl/bgh3d_cfg.sv
`timescale 1ns / 1ps
// Configuration register file for the 3D binary geohash block.
// Depends on bgh3d_pkg.
module bgh3d_cfg
    import bgh3d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_index,
    input  logic [COORD_W-1:0] wr_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_LOWER_X:     cfg_next.lower[0]    = wr_data;
                REG_LOWER_Y:     cfg_next.lower[1]    = wr_data;
                REG_LOWER_Z:     cfg_next.lower[2]    = wr_data;
                REG_UPPER_X:     cfg_next.upper[0]    = wr_data;
                REG_UPPER_Y:     cfg_next.upper[1]    = wr_data;
                REG_UPPER_Z:     cfg_next.upper[2]    = wr_data;
                REG_HASH_LENGTH: cfg_next.hash_length = wr_data[LEN_W-1:0];
                REG_DIMS_USED:   cfg_next.dims_used   = wr_data[DIMS_W-1:0];
                default:         cfg_next = cfg_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower       <= {NUM_DIMS{LOWER_RESET}};
            cfg_reg.upper       <= {NUM_DIMS{UPPER_RESET}};
            cfg_reg.hash_length <= LEN_RESET;
            cfg_reg.dims_used   <= DIMS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/bgh3d_stage.sv
`timescale 1ns / 1ps
// One bisection stage: midpoint of the selected dimension and, when active,
// one hash bit and bound update; registered output. Depends on bgh3d_pkg.
module bgh3d_stage
    import bgh3d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  stage_t            in_data,
    input  logic [DIMS_W-1:0] dim_sel,
    input  logic              active,
    output logic              out_valid,
    output stage_t            out_data
);

    logic signed [COORD_W:0]   sum;
    logic signed [COORD_W:0]   rnd;
    logic signed [COORD_W-1:0] mid;
    logic signed [COORD_W-1:0] lo_sel;
    logic signed [COORD_W-1:0] hi_sel;
    logic signed [COORD_W-1:0] pt_sel;
    logic                      bit_val;
    logic                      valid_reg;
    stage_t                    data_reg;
    stage_t                    data_next;

    always_comb
    begin
        case (dim_sel)
            2'd1:
            begin
                lo_sel = $signed(in_data.lo[1]);
                hi_sel = $signed(in_data.hi[1]);
                pt_sel = $signed(in_data.pt[1]);
            end
            2'd2:
            begin
                lo_sel = $signed(in_data.lo[2]);
                hi_sel = $signed(in_data.hi[2]);
                pt_sel = $signed(in_data.pt[2]);
            end
            default:
            begin
                lo_sel = $signed(in_data.lo[0]);
                hi_sel = $signed(in_data.hi[0]);
                pt_sel = $signed(in_data.pt[0]);
            end
        endcase
    end

    // Half-sum rounded half away from zero: add one before the shift only
    // for a non-negative sum
    assign sum     = {lo_sel[COORD_W-1], lo_sel} + {hi_sel[COORD_W-1], hi_sel};
    assign rnd     = (sum + $signed({{COORD_W{1'b0}}, ~sum[COORD_W]})) >>> 1;
    assign mid     = rnd[COORD_W-1:0];
    assign bit_val = (pt_sel >= mid);

    always_comb
    begin
        data_next = in_data;
        if (active)
        begin
            data_next.code = {in_data.code[HASH_W-2:0], bit_val};
            if (bit_val)
                data_next.lo[dim_sel] = mid;
            else
                data_next.hi[dim_sel] = mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
